// ===== rtl/core/nnbs_pkg.sv =====
// Shared types and constants for the nearest-neighbor BMP scaler core.
// No dependencies; the core and its checker both use this package.
`timescale 1ns / 1ps

package nnbs_pkg;

  // Default sizing of the line buffer and of the enlargement factor
  localparam int unsigned DefMaxWidth = 4096;
  localparam int unsigned DefMaxScale = 8;

  // Field widths fixed by the pixel format and the register map
  localparam int unsigned ChanW    = 8;
  localparam int unsigned PixW     = 3 * ChanW;
  localparam int unsigned ScaleW   = 4;
  localparam int unsigned InWidthW = 13;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned PadW     = 2;

  typedef logic [PixW-1:0] pix_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCALE_FACTOR = 2'd0,
    CFG_HALF_MODE    = 2'd1,
    CFG_INPUT_WIDTH  = 2'd2
  } cfg_idx_e;

  // Request kinds on the input channel
  typedef enum logic {
    REQ_PIXEL  = 1'b0,
    REQ_REPLAY = 1'b1
  } req_type_e;

endpackage

// ===== rtl/core/nearest_neighbor_bmp_scaler_core.sv =====
// Nearest-neighbor BMP scaler: line buffer RAM, replay control, copy emitter.
// Depends on nnbs_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_stall_o): one transaction is either a
//   pixel (req_type_i = 0) or a replay tick (req_type_i = 1). Pixels come in
//   scanline order, input_width per line.
//   Output channel (out_valid_o / out_stall_i): one transaction per output
//   pixel; last_o marks the final copy caused by one input transaction,
//   row_end_o / pad_count_o mark the end of an output scanline.
//   Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i; write
//   only while the block is idle.
//   Path: an accepted transaction goes into the read stage (with the line
//   buffer read for a replay) and then into the output register.
//   Integer mode: n copies per transaction, one copy per cycle out of the
//   single output register while the receiver does not stall; half mode: one.
//   Dropped pixels and idle ticks are taken but enter no stage.
//   Reset clears position and replay state; the line buffer is not cleared
//   and needs no clearing pass. Registers reset to factor 1, integer mode,
//   width 1. When the receiver stalls, the output register holds its copy and
//   the input stalls once the one-entry read stage behind it is full.
module nearest_neighbor_bmp_scaler_core #(
  parameter int unsigned MAX_WIDTH = nnbs_pkg::DefMaxWidth,
  parameter int unsigned MAX_SCALE = nnbs_pkg::DefMaxScale
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [nnbs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nnbs_pkg::CfgDataW-1:0] cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [nnbs_pkg::ChanW-1:0]    blue_i,
  input  logic [nnbs_pkg::ChanW-1:0]    green_i,
  input  logic [nnbs_pkg::ChanW-1:0]    red_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [nnbs_pkg::ChanW-1:0]    out_blue_o,
  output logic [nnbs_pkg::ChanW-1:0]    out_green_o,
  output logic [nnbs_pkg::ChanW-1:0]    out_red_o,
  output logic                          row_end_o,
  output logic [nnbs_pkg::PadW-1:0]     pad_count_o,
  output logic                          last_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CNT_W = $clog2(MAX_SCALE + 1);

  // Read stage between acceptance and the output register
  typedef struct packed {
    logic                   replay;
    nnbs_pkg::pix_t         pix;
    logic [CNT_W-1:0]       copies;
    logic                   row_end;
    logic [nnbs_pkg::PadW-1:0] pad;
  } stage_t;

  // Configuration registers
  logic [nnbs_pkg::ScaleW-1:0]   scale_q;
  logic                          half_q;
  logic [nnbs_pkg::InWidthW-1:0] width_q;

  // Position and replay state
  logic [CW-1:0]    col_q, col_d;
  logic             row_odd_q, row_odd_d;
  logic [CNT_W-1:0] rows_left_q, rows_left_d;
  logic [CW-1:0]    rep_col_q, rep_col_d;

  // Line buffer and its registered read port
  nnbs_pkg::pix_t mem_q [MAX_WIDTH];
  nnbs_pkg::pix_t rd_q;

  stage_t s1_q, s1_d;
  logic   s1_valid_q;

  // Output register
  logic             em_valid_q;
  logic [CNT_W-1:0] em_cnt_q;
  nnbs_pkg::pix_t   em_pix_q;
  logic             em_end_q;
  logic [nnbs_pkg::PadW-1:0] em_pad_q;

  logic             in_acc, is_replay, produce, mem_we, mem_re;
  logic             out_fire, em_free, s1_move;
  logic [31:0]      sf32, iw32;
  logic [CNT_W-1:0] n_eff;
  logic [WW-1:0]    w_eff, two_ow;
  logic [WW:0]      col_ext;
  logic [CW-1:0]    wm1, col_sel, rep_sel, mem_addr;
  logic             end_in, rep_end, half_keep, half_end;
  logic [3:0]       wn_prod;
  logic [2:0]       w3;
  logic [nnbs_pkg::PadW-1:0] pad_int, pad_half;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= nnbs_pkg::ScaleW'(1);
      half_q  <= 1'b0;
      width_q <= nnbs_pkg::InWidthW'(1);
    end else if (cfg_we_i) begin
      unique case (nnbs_pkg::cfg_idx_e'(cfg_idx_i))
        nnbs_pkg::CFG_SCALE_FACTOR: scale_q <= cfg_data_i[nnbs_pkg::ScaleW-1:0];
        nnbs_pkg::CFG_HALF_MODE:    half_q  <= cfg_data_i[0];
        nnbs_pkg::CFG_INPUT_WIDTH:  width_q <= cfg_data_i[nnbs_pkg::InWidthW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp factor and width into their legal ranges
  always_comb begin
    sf32 = 32'(scale_q);
    iw32 = 32'(width_q);
    if (sf32 == 32'd0) begin
      n_eff = CNT_W'(1);
    end else if (sf32 > MAX_SCALE) begin
      n_eff = CNT_W'(MAX_SCALE);
    end else begin
      n_eff = CNT_W'(sf32);
    end
    if (iw32 == 32'd0) begin
      w_eff = WW'(1);
    end else if (iw32 > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(iw32);
    end
  end

  // Column selection, end-of-line detection and pad counts
  always_comb begin
    wm1     = CW'(w_eff - WW'(1));
    col_sel = (col_q >= wm1) ? wm1 : col_q;
    rep_sel = (rep_col_q >= wm1) ? wm1 : rep_col_q;
    end_in  = (col_sel == wm1);
    rep_end = (rep_sel == wm1);
    // half mode keeps even columns below 2*(w/2)
    two_ow    = {w_eff[WW-1:1], 1'b0};
    col_ext   = (WW+1)'(col_sel);
    half_keep = ~col_sel[0] && (col_ext < {1'b0, two_ow});
    half_end  = (col_ext + (WW+1)'(2)) == {1'b0, two_ow};
    // pad = (output width) mod 4
    wn_prod  = {2'b00, w_eff[1:0]} * {2'b00, 2'(n_eff)};
    pad_int  = wn_prod[1:0];
    w3       = 3'(w_eff);
    pad_half = w3[2:1];
  end

  // Handshakes
  assign out_fire   = em_valid_q && !out_stall_i;
  assign em_free    = !em_valid_q || (out_fire && em_cnt_q == CNT_W'(1));
  assign s1_move    = s1_valid_q && em_free;
  assign in_stall_o = s1_valid_q && !em_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_replay  = (nnbs_pkg::req_type_e'(req_type_i) == nnbs_pkg::REQ_REPLAY);

  // Decide what an accepted transaction does
  always_comb begin
    col_d       = col_q;
    row_odd_d   = row_odd_q;
    rows_left_d = rows_left_q;
    rep_col_d   = rep_col_q;
    produce     = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = col_sel;
    s1_d        = s1_q;
    if (in_acc) begin
      if (is_replay) begin
        if (rows_left_q != '0) begin
          produce  = 1'b1;
          mem_re   = 1'b1;
          mem_addr = rep_sel;
          s1_d     = '{replay: 1'b1, pix: '0, copies: n_eff, row_end: rep_end,
                       pad: pad_int};
          if (rep_end) begin
            rep_col_d   = '0;
            rows_left_d = rows_left_q - CNT_W'(1);
          end else begin
            rep_col_d = rep_sel + CW'(1);
          end
        end
      end else if (rows_left_q == '0) begin
        if (half_q) begin
          produce = !row_odd_q && half_keep;
          s1_d    = '{replay: 1'b0, pix: {red_i, green_i, blue_i},
                      copies: CNT_W'(1), row_end: half_end, pad: pad_half};
        end else begin
          produce = 1'b1;
          mem_we  = 1'b1;
          s1_d    = '{replay: 1'b0, pix: {red_i, green_i, blue_i},
                      copies: n_eff, row_end: end_in, pad: pad_int};
          if (end_in) begin
            rows_left_d = n_eff - CNT_W'(1);
            rep_col_d   = '0;
          end
        end
        if (end_in) begin
          col_d     = '0;
          row_odd_d = !row_odd_q;
        end else begin
          col_d = col_sel + CW'(1);
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_odd_q   <= 1'b0;
      rows_left_q <= '0;
      rep_col_q   <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_odd_q   <= row_odd_d;
      rows_left_q <= rows_left_d;
      rep_col_q   <= rep_col_d;
      if (in_acc && produce) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && produce) begin
      s1_q <= s1_d;
    end
  end

  // Line buffer: one write or one read per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= s1_d.pix;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  // Output register: emits one copy per cycle while the receiver does not stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
      em_cnt_q   <= '0;
    end else if (s1_move) begin
      em_valid_q <= 1'b1;
      em_cnt_q   <= s1_q.copies;
    end else if (out_fire) begin
      em_cnt_q <= em_cnt_q - CNT_W'(1);
      if (em_cnt_q == CNT_W'(1)) begin
        em_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      em_pix_q <= s1_q.replay ? rd_q : s1_q.pix;
      em_end_q <= s1_q.row_end;
      em_pad_q <= s1_q.pad;
    end
  end

  assign out_valid_o = em_valid_q;
  assign out_blue_o  = em_pix_q[nnbs_pkg::ChanW-1:0];
  assign out_green_o = em_pix_q[2*nnbs_pkg::ChanW-1:nnbs_pkg::ChanW];
  assign out_red_o   = em_pix_q[3*nnbs_pkg::ChanW-1:2*nnbs_pkg::ChanW];
  assign last_o      = (em_cnt_q == CNT_W'(1));
  assign row_end_o   = last_o && em_end_q;
  assign pad_count_o = row_end_o ? em_pad_q : '0;

endmodule

// ===== rtl/core/nnbs_checker.sv =====
// Port-level assertions for the scaler core, bound to the core module.
// Depends on nnbs_pkg and nearest_neighbor_bmp_scaler_core.
`timescale 1ns / 1ps

module nnbs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [nnbs_pkg::ChanW-1:0] out_blue_o,
  input logic [nnbs_pkg::ChanW-1:0] out_green_o,
  input logic [nnbs_pkg::ChanW-1:0] out_red_o,
  input logic                       row_end_o,
  input logic [nnbs_pkg::PadW-1:0]  pad_count_o,
  input logic                       last_o
);

  // A stalled output transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_blue_o) && $stable(out_green_o)
      && $stable(out_red_o) && $stable(last_o) && $stable(row_end_o))
    else $error("output payload changed while stalled");

  // Copies of one pixel follow without a gap
  a_copy_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a run of copies");

  // All copies of one pixel carry the same color
  a_copy_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_blue_o == $past(out_blue_o) && out_green_o == $past(out_green_o)
      && out_red_o == $past(out_red_o))
    else $error("copy differs from its pixel");

  // Scanline end falls on a final copy; pad is zero elsewhere
  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (row_end_o || pad_count_o != '0) |-> last_o && row_end_o)
    else $error("row end or pad off a final copy");

endmodule

bind nearest_neighbor_bmp_scaler_core nnbs_checker u_nnbs_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for nearest_neighbor_bmp_scaler_core: directed, random
// and backpressure runs. Depends on nnbs_pkg and the core RTL; an in-bench
// pixel predictor checks every output transaction.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MaxWidth     = nnbs_pkg::DefMaxWidth;
  localparam int unsigned MaxScale     = nnbs_pkg::DefMaxScale;
  // random phase stops once this many transactions went in (all phases
  // counted); its last row overshoots the budget a little
  localparam int unsigned ItemBudget   = 345;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned HoldOffLen   = 240;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned ShowMismatch = 10;

  // one output pixel as the block presents it
  typedef struct packed {
    logic [nnbs_pkg::ChanW-1:0] blue;
    logic [nnbs_pkg::ChanW-1:0] green;
    logic [nnbs_pkg::ChanW-1:0] red;
    logic                       row_end;
    logic [nnbs_pkg::PadW-1:0]  pad;
    logic                       last;
  } px_out_t;

  logic                          clk_i;
  logic                          rst_ni    = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [nnbs_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [nnbs_pkg::CfgDataW-1:0] cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic                          req_type  = nnbs_pkg::REQ_PIXEL;
  logic [nnbs_pkg::ChanW-1:0]    blue      = '0;
  logic [nnbs_pkg::ChanW-1:0]    green     = '0;
  logic [nnbs_pkg::ChanW-1:0]    red       = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [nnbs_pkg::ChanW-1:0]    out_blue;
  logic [nnbs_pkg::ChanW-1:0]    out_green;
  logic [nnbs_pkg::ChanW-1:0]    out_red;
  logic                          row_end;
  logic [nnbs_pkg::PadW-1:0]     pad_count;
  logic                          last;

  nearest_neighbor_bmp_scaler_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .req_type_i  (req_type),
    .blue_i      (blue),
    .green_i     (green),
    .red_i       (red),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_blue_o  (out_blue),
    .out_green_o (out_green),
    .out_red_o   (out_red),
    .row_end_o   (row_end),
    .pad_count_o (pad_count),
    .last_o      (last)
  );

  // register shadow
  logic [nnbs_pkg::ScaleW-1:0]   reg_scale = 4'd1;
  logic                          reg_half  = 1'b0;
  logic [nnbs_pkg::InWidthW-1:0] reg_width = 13'd1;

  // predictor state
  nnbs_pkg::pix_t lbuf [MaxWidth];
  int unsigned col_pos      = 0;
  bit          odd_row      = 1'b0;
  int unsigned replays_owed = 0;
  int unsigned replay_pos   = 0;
  int unsigned rows_done    = 0;

  px_out_t     px_expected[$];

  // bench bookkeeping
  bit          tx_idle      = 1'b1;
  bit          rx_idle      = 1'b1;
  int unsigned hold_off     = 0;
  int unsigned items_in     = 0;
  int unsigned results_seen = 0;
  int unsigned settings_run = 0;
  int unsigned fail_cnt     = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // BMP pad bytes for a scanline of ow pixels
  function automatic logic [nnbs_pkg::PadW-1:0] pad_bytes(int unsigned ow);
    return nnbs_pkg::PadW'((4 - (3 * ow) % 4) % 4);
  endfunction

  function automatic void push_copies(nnbs_pkg::pix_t pix, int unsigned n, bit at_end,
                                      logic [nnbs_pkg::PadW-1:0] pad);
    px_out_t r;
    for (int unsigned i = 0; i < n; i++) begin
      r.blue    = pix[7:0];
      r.green   = pix[15:8];
      r.red     = pix[23:16];
      r.row_end = at_end && (i == n - 1);
      r.pad     = r.row_end ? pad : '0;
      r.last    = (i == n - 1);
      px_expected.push_back(r);
    end
  endfunction

  // Expected output pixels of one accepted transaction; returns 0 when the
  // block just ignores it (pixel during a replay, tick with nothing owed).
  function automatic bit scaler_predict(nnbs_pkg::req_type_e kind, nnbs_pkg::pix_t pix);
    int unsigned w, n, col, ow;
    bit          at_end;
    w = (reg_width == 0) ? 1 : (reg_width > MaxWidth) ? MaxWidth : reg_width;
    n = (reg_scale == 0) ? 1 : (reg_scale > MaxScale) ? MaxScale : reg_scale;
    if (kind == nnbs_pkg::REQ_REPLAY) begin
      if (replays_owed == 0) return 1'b0;
      col    = (replay_pos >= w - 1) ? w - 1 : replay_pos;
      at_end = (col == w - 1);
      push_copies(lbuf[col], n, at_end, pad_bytes(w * n));
      if (at_end) begin
        replay_pos = 0;
        replays_owed--;
      end else begin
        replay_pos = col + 1;
      end
      return 1'b1;
    end
    if (replays_owed != 0) return 1'b0;
    col    = (col_pos >= w - 1) ? w - 1 : col_pos;
    at_end = (col == w - 1);
    if (reg_half) begin
      // even rows, even columns below twice the halved width
      ow = w / 2;
      if (!odd_row && (col % 2 == 0) && col < 2 * ow)
        push_copies(pix, 1, col == 2 * ow - 2, pad_bytes(ow));
    end else begin
      lbuf[col] = pix;
      push_copies(pix, n, at_end, pad_bytes(w * n));
      if (at_end) begin
        replays_owed = n - 1;
        replay_pos   = 0;
      end
    end
    if (at_end) begin
      col_pos = 0;
      odd_row = !odd_row;
      rows_done++;
    end else begin
      col_pos = col + 1;
    end
    return 1'b1;
  endfunction

  // Offer one transaction, hold it until accepted, then predict it.
  task automatic send_item(nnbs_pkg::req_type_e kind, nnbs_pkg::pix_t pix,
                           output bit effective);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(14, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    blue     <= pix[7:0];
    green    <= pix[15:8];
    red      <= pix[23:16];
    do @(posedge clk_i); while (in_stall);
    effective = scaler_predict(kind, pix);
    items_in++;
  endtask

  task automatic send(nnbs_pkg::req_type_e kind, nnbs_pkg::pix_t pix);
    bit effective;
    send_item(kind, pix, effective);
  endtask

  // Release the input and let every outstanding result drain out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (px_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(nnbs_pkg::cfg_idx_e idx, logic [nnbs_pkg::CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    unique case (idx)
      nnbs_pkg::CFG_SCALE_FACTOR: reg_scale = data[nnbs_pkg::ScaleW-1:0];
      nnbs_pkg::CFG_HALF_MODE:    reg_half  = data[0];
      nnbs_pkg::CFG_INPUT_WIDTH:  reg_width = data[nnbs_pkg::InWidthW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned scale, bit half, int unsigned width);
    wait_idle();
    write_reg(nnbs_pkg::CFG_SCALE_FACTOR, nnbs_pkg::CfgDataW'(scale));
    write_reg(nnbs_pkg::CFG_HALF_MODE, nnbs_pkg::CfgDataW'(half));
    write_reg(nnbs_pkg::CFG_INPUT_WIDTH, nnbs_pkg::CfgDataW'(width));
    settings_run++;
  endtask

  function automatic nnbs_pkg::pix_t rand_pix();
    unique case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      default: return nnbs_pkg::pix_t'($urandom);
    endcase
  endfunction

  // Well-formed scanlines driven from the predicted position, with a little
  // noise: stray ticks among the pixels and pixels offered during replays.
  task automatic run_rows(int unsigned rows, inout int unsigned taken);
    int unsigned goal;
    bit          effective;
    goal = rows_done + rows;
    while (rows_done < goal || replays_owed != 0) begin
      if (replays_owed != 0)
        send_item(($urandom_range(9, 0) == 0) ? nnbs_pkg::REQ_PIXEL : nnbs_pkg::REQ_REPLAY,
                  rand_pix(), effective);
      else
        send_item(($urandom_range(11, 0) == 0) ? nnbs_pkg::REQ_REPLAY : nnbs_pkg::REQ_PIXEL,
                  rand_pix(), effective);
      if (effective) taken++;
    end
  endtask

  // ---------------------------------------------------------------- tests

  // reset values: factor 1, integer mode, width 1
  task automatic test_reset_defaults();
    send(nnbs_pkg::REQ_PIXEL, 24'hFFFFFF);
    send(nnbs_pkg::REQ_REPLAY, 24'h000000);
  endtask

  // factor written as 0 and above the maximum, width as 0; replays served
  task automatic test_out_of_range_registers();
    set_config(0, 1'b0, 0);
    send(nnbs_pkg::REQ_PIXEL, 24'h000000);
    set_config(9, 1'b0, 1);
    send(nnbs_pkg::REQ_PIXEL, 24'h5AA5C3);
    send(nnbs_pkg::REQ_PIXEL, 24'h123456);
    repeat (MaxScale - 1) send(nnbs_pkg::REQ_REPLAY, 24'h000000);
  endtask

  // oversize width, then width lowered so the current column ends the row
  task automatic test_width_lowered_mid_row();
    set_config(2, 1'b0, 8191);
    repeat (3) send(nnbs_pkg::REQ_PIXEL, rand_pix());
    wait_idle();
    write_reg(nnbs_pkg::CFG_INPUT_WIDTH, 13'd2);
    send(nnbs_pkg::REQ_PIXEL, rand_pix());
    repeat (2) send(nnbs_pkg::REQ_REPLAY, 24'h000000);
  endtask

  // half mode: wide row cut short, and width 1 with an empty output row
  task automatic test_half_mode_edges();
    set_config(1, 1'b1, 8191);
    repeat (3) send(nnbs_pkg::REQ_PIXEL, rand_pix());
    wait_idle();
    write_reg(nnbs_pkg::CFG_INPUT_WIDTH, 13'd3);
    send(nnbs_pkg::REQ_PIXEL, rand_pix());
    set_config(1, 1'b1, 1);
    send(nnbs_pkg::REQ_PIXEL, rand_pix());
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_output_backpressure();
    int unsigned taken;
    taken = 0;
    set_config(8, 1'b0, 3);
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_off = HoldOffLen;
    run_rows(1, taken);
  endtask

  task automatic test_random_streams();
    int unsigned taken, scale, width;
    bit          half;
    taken = 0;
    while (items_in < ItemBudget) begin
      scale = $urandom_range(15, 0);
      half  = ($urandom_range(3, 0) == 0);
      case ($urandom_range(9, 0))
        0:       width = 0;
        1:       width = 1;
        default: width = $urandom_range(10, 2);
      endcase
      set_config(scale, half, width);
      tx_idle = ($urandom_range(2, 0) != 0);
      rx_idle = ($urandom_range(2, 0) != 0);
      run_rows(1, taken);
    end
  endtask

  // ---------------------------------------------------------------- checking

  initial begin
    int unsigned n;
    px_out_t     got, want;
    @(posedge rst_ni);
    forever begin
      if (hold_off != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end
      n = rx_idle ? $urandom_range(14, 0) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
      got = '{out_blue, out_green, out_red, row_end, pad_count, last};
      results_seen++;
      if (px_expected.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= ShowMismatch)
          $display("[%0t] unexpected output pixel: %p", $realtime, got);
      end else begin
        want = px_expected.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= ShowMismatch)
            $display("[%0t] pixel %0d mismatch: exp %p got %p",
                     $realtime, results_seen, want, got);
        end
      end
    end
  end

  // watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("** nearest_neighbor_bmp_scaler_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_out_of_range_registers();
    test_width_lowered_mid_row();
    test_half_mode_edges();
    test_output_backpressure();
    test_random_streams();
    wait_idle();
    if (px_expected.size() != 0) fail_cnt++;
    $display("Run covered %0d input transactions and %0d output pixels over %0d settings,",
             items_in, results_seen, settings_run);
    $display("including integer and half modes, replays, dropped pixels and a long hold-off.");
    if (fail_cnt == 0) begin
      $display("** nearest_neighbor_bmp_scaler_core: PASSED **");
    end else begin
      $display("%0d failing output transactions", fail_cnt);
      $display("** nearest_neighbor_bmp_scaler_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/nnbs_pkg.sv
rtl/core/nearest_neighbor_bmp_scaler_core.sv
rtl/core/nnbs_checker.sv
bench/tb_top.sv
